[sv/rpcd_pkg.sv]
// Shared widths, constants and types of the remote pulse code decoder.
package rpcd_pkg;

   localparam int DUR_W = 16;
   localparam int DUR_MAX = (1 << DUR_W) - 1;
   localparam int TOL_W = 7;
   localparam int CODE_W = 24;
   localparam int BASE_W = 12;

   localparam int FRAME_DURATIONS_DEF = 49;
   localparam int SYNC_UNITS_DEF = 31;
   localparam int LONG_FACTOR = 3;
   localparam int PCT_SCALE = 100;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(25);

   // One decoded frame, as it leaves the frame logic.
   typedef struct packed {
      logic              ok;
      logic [CODE_W-1:0] code;
      logic [BASE_W-1:0] base_unit;
   } rpcd_result_type;

endpackage

[sv/remote_pulse_code_decoder_core.sv]
// Top level of the remote pulse code decoder: handshakes, tolerance register, result register.
//
// The decoder takes one pulse duration per transaction and sustains one transaction per clock
// cycle. A duration is held in an input register and then updates the frame state (pulse
// count, base unit, window product, pending high half and code shift register) in a single
// pass; a duration flagged last also loads the result register, from which its result
// transaction is offered once the duration leaves the input register. Durations that are not
// flagged last never stall in the input register. A last duration waits there only while the
// previous result has not been taken, and the single-pass frame update is what sets the rate.
// The base unit is the sync gap divided by SYNC_UNITS through a reciprocal multiply; the
// tolerance window is the base unit times the tolerance captured at the sync gap, formed at
// the second duration and compared as 100 * (|width - center| + 1) <= product. The tolerance
// register resets to 25 percent and should be written only while no frame is in progress.
// There is no clearing pass after reset.
module remote_pulse_code_decoder_core #(
   parameter int FRAME_DURATIONS = rpcd_pkg::FRAME_DURATIONS_DEF,
   parameter int SYNC_UNITS = rpcd_pkg::SYNC_UNITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // Duration transactions.
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rpcd_pkg::DUR_W-1:0]   req_duration,
   input  logic                         req_last,
   // Result transactions.
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_ok,
   output logic [rpcd_pkg::CODE_W-1:0]  rsp_code,
   output logic [rpcd_pkg::BASE_W-1:0]  rsp_base_unit,
   // Tolerance register write.
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rpcd_pkg::TOL_W-1:0]   csr_tolerance_percent
);
   import rpcd_pkg::*;

   logic [TOL_W-1:0]  tol_value_ff;

   logic              in_valid_ff;
   logic [DUR_W-1:0]  in_duration_ff;
   logic              in_last_ff;
   logic              in_fire;

   logic              rsp_valid_ff;
   rpcd_result_type   rsp_data_ff;
   rpcd_result_type   frame_result;

   // The tolerance register is always ready; a write lands on the next edge.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_value_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_value_ff <= csr_tolerance_percent;
      end
   end

   // The held duration moves on unless it is a last one and the result register is still full.
   assign in_fire   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || in_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_duration_ff <= req_duration;
         in_last_ff     <= req_last;
      end
   end

   rpcd_frame_decode #(
      .FRAME_DURATIONS(FRAME_DURATIONS),
      .SYNC_UNITS(SYNC_UNITS)
   ) u_frame (
      .clock(clock),
      .reset(reset),
      .step_i(in_fire),
      .duration_i(in_duration_ff),
      .last_i(in_last_ff),
      .tolerance_i(tol_value_ff),
      .result_o(frame_result)
   );

   // Result register: loaded by a last duration, emptied when the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_fire && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire && in_last_ff) begin
         rsp_data_ff <= frame_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_data_ff.ok;
   assign rsp_code      = rsp_data_ff.code;
   assign rsp_base_unit = rsp_data_ff.base_unit;

   // A duration that is not the last of its frame never waits in the input register.
   a_plain_never_stalls : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_last_ff |-> in_fire)
      else $error("non-last duration stalled in the input register");

   // A last duration that moves on always yields a result transaction on the next cycle.
   a_last_gives_result : assert property (@(posedge clock) disable iff (reset)
      in_fire && in_last_ff |=> rsp_valid_ff)
      else $error("last duration did not load the result register");

   // A pending result that is not taken holds back a following last duration.
   a_result_not_overrun : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready && in_valid_ff && in_last_ff |-> !in_fire && !req_ready)
      else $error("result register overrun by a last duration");

   // A failed frame never reports a code.
   a_fail_zero_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.ok |-> rsp_data_ff.code == '0)
      else $error("failed frame carries a nonzero code");

endmodule

[sv/rpcd_window_check.sv]
// Tests whether one pulse width lies strictly inside the tolerance window around a center.
module rpcd_window_check #(
   parameter int LONG_W = 14,
   parameter int PROD_W = 19
) (
   input  logic [rpcd_pkg::DUR_W-1:0] value_i,
   input  logic [LONG_W-1:0]          center_i,
   input  logic [PROD_W-1:0]          prod_i,
   output logic                       inside_o
);
   import rpcd_pkg::*;

   localparam int DIFF_W = (DUR_W > LONG_W) ? DUR_W : LONG_W;
   localparam int CMP_W = ((DIFF_W + 8) > PROD_W) ? (DIFF_W + 8) : PROD_W;

   logic [DIFF_W-1:0] value_ext;
   logic [DIFF_W-1:0] center_ext;
   logic [DIFF_W-1:0] abs_diff;
   logic [CMP_W-1:0]  scaled;

   // |v - c| < floor(P / 100) is the same as 100 * (|v - c| + 1) <= P,
   // which needs no divider and covers windows wider than the center.
   always_comb begin
      value_ext  = DIFF_W'(value_i);
      center_ext = DIFF_W'(center_i);
      if (value_ext >= center_ext) begin
         abs_diff = value_ext - center_ext;
      end else begin
         abs_diff = center_ext - value_ext;
      end
      scaled   = (CMP_W'(abs_diff) + CMP_W'(1)) * CMP_W'(PCT_SCALE);
      inside_o = (scaled <= CMP_W'(prod_i));
   end

endmodule

[sv/rpcd_frame_decode.sv]
// Frame state of the decoder: pulse counting, base unit, pair checks and the code shift register.
module rpcd_frame_decode #(
   parameter int FRAME_DURATIONS = rpcd_pkg::FRAME_DURATIONS_DEF,
   parameter int SYNC_UNITS = rpcd_pkg::SYNC_UNITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_i,
   input  logic [rpcd_pkg::DUR_W-1:0]     duration_i,
   input  logic                           last_i,
   input  logic [rpcd_pkg::TOL_W-1:0]     tolerance_i,
   output rpcd_pkg::rpcd_result_type      result_o
);
   import rpcd_pkg::*;

   localparam int CNT_W = $clog2(FRAME_DURATIONS + 2);
   localparam int UNIT_W = $clog2(DUR_MAX / SYNC_UNITS + 1);
   localparam int SHIFT = DUR_W + $clog2(SYNC_UNITS);
   localparam int DIV_W = SHIFT + UNIT_W;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + longint'(SYNC_UNITS) - 1) / longint'(SYNC_UNITS);
   localparam int LONG_W = UNIT_W + $clog2(LONG_FACTOR + 1);
   localparam int PROD_W = UNIT_W + TOL_W;
   localparam logic FRAME_ODD = (FRAME_DURATIONS % 2) != 0;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [UNIT_W-1:0] unit_ff, unit_in;
   logic [TOL_W-1:0]  frame_tol_ff, frame_tol_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DUR_W-1:0]  first_half_ff, first_half_in;
   logic [CODE_W-1:0] shift_ff, shift_in;
   logic              bad_ff, bad_in;

   logic [DIV_W-1:0]  div_prod;
   logic [UNIT_W-1:0] div_quot;
   logic [LONG_W-1:0] short_c, long_c;
   logic              is_first, in_frame, is_pair;
   logic              fh_short, fh_long, d_short, d_long;
   logic              zero_ok, one_ok;

   // Division of the sync gap by a constant: reciprocal multiply, exact for 16-bit inputs.
   assign div_prod = DIV_W'(duration_i) * DIV_W'(RECIP);
   assign div_quot = div_prod[SHIFT +: UNIT_W];

   assign short_c = LONG_W'(unit_ff);
   assign long_c  = LONG_W'(unit_ff) * LONG_W'(LONG_FACTOR);

   rpcd_window_check #(.LONG_W(LONG_W), .PROD_W(PROD_W)) u_fh_short (
      .value_i(first_half_ff), .center_i(short_c), .prod_i(prod_ff), .inside_o(fh_short)
   );
   rpcd_window_check #(.LONG_W(LONG_W), .PROD_W(PROD_W)) u_fh_long (
      .value_i(first_half_ff), .center_i(long_c), .prod_i(prod_ff), .inside_o(fh_long)
   );
   rpcd_window_check #(.LONG_W(LONG_W), .PROD_W(PROD_W)) u_d_short (
      .value_i(duration_i), .center_i(short_c), .prod_i(prod_ff), .inside_o(d_short)
   );
   rpcd_window_check #(.LONG_W(LONG_W), .PROD_W(PROD_W)) u_d_long (
      .value_i(duration_i), .center_i(long_c), .prod_i(prod_ff), .inside_o(d_long)
   );

   always_comb begin
      is_first = (count_ff == '0);
      in_frame = (count_ff < CNT_W'(FRAME_DURATIONS));
      is_pair  = in_frame && !is_first && !count_ff[0];
      zero_ok  = fh_short && d_long;
      one_ok   = fh_long && d_short;

      unit_in       = is_first ? div_quot : unit_ff;
      frame_tol_in  = is_first ? tolerance_i : frame_tol_ff;
      prod_in       = (count_ff == CNT_W'(1)) ?
                      PROD_W'(unit_ff) * PROD_W'(frame_tol_ff) : prod_ff;
      first_half_in = (in_frame && !is_first && count_ff[0]) ? duration_i : first_half_ff;

      shift_in = shift_ff;
      bad_in   = bad_ff;
      if (is_first) begin
         shift_in = '0;
         bad_in   = 1'b0;
      end else if (!in_frame) begin
         bad_in = 1'b1;
      end else if (is_pair) begin
         if (zero_ok) begin
            shift_in = {shift_ff[CODE_W-2:0], 1'b0};
         end else if (one_ok) begin
            shift_in = {shift_ff[CODE_W-2:0], 1'b1};
         end else begin
            bad_in = 1'b1;
         end
      end

      count_in = in_frame ? (count_ff + CNT_W'(1)) : CNT_W'(FRAME_DURATIONS + 1);

      result_o.ok        = (count_in == CNT_W'(FRAME_DURATIONS)) && !bad_in && FRAME_ODD;
      result_o.code      = result_o.ok ? shift_in : '0;
      result_o.base_unit = BASE_W'(unit_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (step_i) begin
         count_ff <= last_i ? '0 : count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_i) begin
         unit_ff       <= unit_in;
         frame_tol_ff  <= frame_tol_in;
         prod_ff       <= prod_in;
         first_half_ff <= first_half_in;
         shift_ff      <= shift_in;
         bad_ff        <= bad_in;
      end
   end

endmodule

[tb/tb_remote_pulse_code_decoder_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the remote pulse code decoder core with its own frame decoder.
module tb_remote_pulse_code_decoder_core;
   import rpcd_pkg::*;

   localparam int FRAME_LEN = FRAME_DURATIONS_DEF;
   localparam int SYNC_DIV = SYNC_UNITS_DEF;
   localparam int MAX_UNIT = DUR_MAX / SYNC_DIV;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 320;
   localparam int PRINT_CAP = 40;

   // How the widths of a pair are placed relative to their windows.
   typedef enum {WIDTH_RANDOM, WIDTH_INNER_EDGE, WIDTH_OUTER_EDGE} width_style_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [DUR_W-1:0]  req_duration = '0;
   logic              req_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_ok;
   logic [CODE_W-1:0] rsp_code;
   logic [BASE_W-1:0] rsp_base_unit;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [TOL_W-1:0]  csr_tolerance_percent = '0;

   // Decoder state as the block should hold it.
   int          dec_tolerance = TOL_RESET;
   int          dec_pos = 0;
   int          dec_unit = 0;
   int          dec_window = 0;
   int          dec_high = 0;
   logic [31:0] dec_code = '0;
   bit          dec_broken = 1'b0;

   rpcd_result_type pending_results[$];

   // Tolerance the stimulus shapes its widths for.
   int gen_tolerance = TOL_RESET;
   bit no_idle = 1'b0;
   int hold_request = 0;
   int stall_left = 0;
   int idle_cycles = 0;

   int items_sent = 0;
   int durations_taken = 0;
   int frames_closed = 0;
   int results_taken = 0;
   int ok_frames = 0;
   int csr_writes = 0;
   int mismatches = 0;

   remote_pulse_code_decoder_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_duration          (req_duration),
      .req_last              (req_last),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_ok                (rsp_ok),
      .rsp_code              (rsp_code),
      .rsp_base_unit         (rsp_base_unit),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_tolerance_percent (csr_tolerance_percent)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bounds are signed, so a window wider than the center admits zero.
   function automatic bit in_window(input int width, input int center);
      return width > center - dec_window && width < center + dec_window;
   endfunction

   // Advances the frame state by one duration; returns 1 when a result is due.
   function automatic bit decode_duration(input int dur, input bit lst,
                                          output rpcd_result_type res);
      int pos;
      bit good;
      pos = dec_pos;
      res = '0;
      if (pos == 0) begin
         dec_unit = dur / SYNC_DIV;
         dec_window = (dec_unit * dec_tolerance) / PCT_SCALE;
         dec_code = '0;
         dec_broken = 1'b0;
      end else if (pos < FRAME_LEN) begin
         if (pos % 2 == 1) begin
            dec_high = dur;
         end else if (in_window(dec_high, dec_unit)
                      && in_window(dur, LONG_FACTOR * dec_unit)) begin
            dec_code = dec_code << 1;
         end else if (in_window(dec_high, LONG_FACTOR * dec_unit)
                      && in_window(dur, dec_unit)) begin
            dec_code = (dec_code << 1) | 32'd1;
         end else begin
            dec_broken = 1'b1;
         end
      end else begin
         // Durations past the frame length are never examined.
         dec_broken = 1'b1;
      end
      dec_pos = (pos < FRAME_LEN) ? pos + 1 : FRAME_LEN + 1;
      if (!lst) return 1'b0;
      good = dec_pos == FRAME_LEN && !dec_broken && FRAME_LEN % 2 == 1;
      res.ok = good;
      res.code = good ? dec_code[CODE_W-1:0] : '0;
      res.base_unit = BASE_W'(dec_unit);
      dec_pos = 0;
      dec_unit = 0;
      dec_window = 0;
      dec_high = 0;
      dec_code = '0;
      dec_broken = 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t ns: mismatch, %s", $time, what);
   endtask

   function automatic int random_gap();
      int roll;
      int gap;
      roll = $urandom_range(0, 99);
      if (roll < 55) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      return gap;
   endfunction

   function automatic int clamp_duration(input int value);
      return (value < 0) ? 0 : (value > DUR_MAX) ? DUR_MAX : value;
   endfunction

   function automatic int pick_width(input int center, input int win,
                                     input width_style_type style);
      int lo;
      int hi;
      int width;
      lo = clamp_duration(center - win + 1);
      hi = clamp_duration(center + win - 1);
      case (style)
         WIDTH_INNER_EDGE: width = $urandom_range(0, 1) ? lo : hi;
         WIDTH_OUTER_EDGE: width = clamp_duration($urandom_range(0, 1) ? center - win
                                                                       : center + win);
         default: width = (lo <= hi) ? int'($urandom_range(hi, lo)) : center;
      endcase
      return width;
   endfunction

   // A broken half: on the window edge, pure noise, or the width of the other class.
   function automatic int flawed_width(input int center, input int other, input int win);
      int width;
      case ($urandom_range(0, 2))
         0: width = pick_width(center, win, WIDTH_OUTER_EDGE);
         1: width = $urandom_range(0, DUR_MAX);
         default: width = pick_width(other, win, WIDTH_RANDOM);
      endcase
      return width;
   endfunction

   function automatic int sync_for_unit(input int unit);
      return clamp_duration(unit * SYNC_DIV + $urandom_range(0, SYNC_DIV - 1));
   endfunction

   function automatic int random_unit();
      int roll;
      int unit;
      roll = $urandom_range(0, 99);
      if (roll < 10) unit = $urandom_range(1, 30);
      else if (roll < 15) unit = MAX_UNIT;
      else unit = $urandom_range(40, MAX_UNIT);
      return unit;
   endfunction

   function automatic int random_tolerance();
      int roll;
      int pct;
      roll = $urandom_range(0, 99);
      if (roll < 70) pct = $urandom_range(10, 60);
      else if (roll < 80) pct = $urandom_range(0, 9);
      else if (roll < 90) pct = $urandom_range(61, 99);
      else pct = $urandom_range(100, (1 << TOL_W) - 1);
      return pct;
   endfunction

   // Offers one duration transaction and returns at the edge that takes it.
   task automatic send_duration(input int dur, input bit lst);
      int gap;
      gap = no_idle ? 0 : random_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_duration <= DUR_W'(dur);
      req_last <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Waits until every expected result is in and the block has had time to settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tolerance(input int pct);
      drain_results();
      csr_valid <= 1'b1;
      csr_tolerance_percent <= TOL_W'(pct);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      gen_tolerance = pct;
      csr_writes++;
   endtask

   // Sends a frame whose pairs encode bits, first pair most significant; flaw_pct is the
   // chance that a pair gets one broken half.
   task automatic send_frame(input int sync, input int length, input logic [CODE_W-1:0] bits,
                             input width_style_type style, input int flaw_pct);
      int unit;
      int win;
      int pos;
      int pair;
      int center;
      int other;
      int bad_half;
      int dur;
      bit is_long;
      unit = sync / SYNC_DIV;
      win = unit * gen_tolerance / PCT_SCALE;
      bad_half = 0;
      send_duration(sync, length == 1);
      for (pos = 1; pos < length; pos++) begin
         if (pos >= FRAME_LEN) begin
            dur = $urandom_range(0, DUR_MAX);
         end else begin
            pair = (pos - 1) / 2;
            if (pos % 2 == 1) begin
               bad_half = ($urandom_range(0, 99) < flaw_pct) ? $urandom_range(1, 2) : 0;
            end
            // A one bit is long then short, a zero bit short then long.
            is_long = bits[CODE_W - 1 - pair] == (pos % 2 == 1);
            center = is_long ? LONG_FACTOR * unit : unit;
            other = is_long ? unit : LONG_FACTOR * unit;
            if (bad_half == ((pos % 2 == 1) ? 1 : 2)) dur = flawed_width(center, other, win);
            else dur = pick_width(center, win, style);
         end
         send_duration(dur, pos == length - 1);
      end
   endtask

   task automatic send_noise_frame(input int length);
      int pos;
      for (pos = 0; pos < length; pos++) begin
         send_duration($urandom_range(0, DUR_MAX), pos == length - 1);
      end
   endtask

   task automatic test_clean_frames();
      send_frame(350 * SYNC_DIV + 7, FRAME_LEN, 24'hA5C3F0, WIDTH_RANDOM, 0);
      send_frame(DUR_MAX, FRAME_LEN, 24'hFFFFFF, WIDTH_RANDOM, 0);
      send_frame(100 * SYNC_DIV, FRAME_LEN, 24'h000000, WIDTH_INNER_EDGE, 0);
      send_frame(1000 * SYNC_DIV + SYNC_DIV - 1, FRAME_LEN, 24'h5A5A5A, WIDTH_INNER_EDGE, 0);
   endtask

   task automatic test_frame_length();
      send_frame(sync_for_unit(200), 1, '0, WIDTH_RANDOM, 0);
      send_frame(sync_for_unit(200), 2, '1, WIDTH_RANDOM, 0);
      send_frame(sync_for_unit(700), FRAME_LEN - 1, 24'h123456, WIDTH_RANDOM, 0);
      send_frame(sync_for_unit(700), FRAME_LEN + 1, 24'h654321, WIDTH_RANDOM, 0);
      send_frame(sync_for_unit(900), FRAME_LEN + 21, 24'hC0FFEE, WIDTH_RANDOM, 0);
      // A zero sync gap leaves no window at all.
      send_frame(0, FRAME_LEN, 24'h0F0F0F, WIDTH_RANDOM, 0);
   endtask

   task automatic test_bad_pairs();
      int pos;
      send_frame(sync_for_unit(400), FRAME_LEN, 24'h3C3C3C, WIDTH_OUTER_EDGE, 0);
      send_frame(sync_for_unit(400), FRAME_LEN, 24'h8E1D47, WIDTH_RANDOM, 100);
      send_frame(sync_for_unit(400), FRAME_LEN, 24'h71B2E8, WIDTH_RANDOM, 10);
      for (pos = 0; pos < FRAME_LEN; pos++) begin
         send_duration((pos % 2 == 1) ? 0 : DUR_MAX, pos == FRAME_LEN - 1);
      end
   endtask

   task automatic test_tolerance_extremes();
      int pct_list[5];
      int k;
      pct_list = '{0, 1, 99, 100, (1 << TOL_W) - 1};
      for (k = 0; k < 5; k++) begin
         write_tolerance(pct_list[k]);
         send_frame(sync_for_unit(random_unit()), FRAME_LEN, CODE_W'($urandom),
                    WIDTH_RANDOM, 0);
         send_frame(MAX_UNIT * SYNC_DIV, FRAME_LEN, CODE_W'($urandom), WIDTH_INNER_EDGE, 0);
         send_frame(100 * SYNC_DIV, FRAME_LEN, CODE_W'($urandom), WIDTH_INNER_EDGE, 0);
      end
      write_tolerance(TOL_RESET);
   endtask

   // The receiver stops for a long stretch while short frames keep coming.
   task automatic test_result_backpressure();
      int k;
      hold_request = HOLD_CYCLES;
      no_idle = 1'b1;
      for (k = 0; k < 16; k++) send_frame(sync_for_unit(random_unit()), 1, '0, WIDTH_RANDOM, 0);
      send_frame(sync_for_unit(500), FRAME_LEN, CODE_W'($urandom), WIDTH_RANDOM, 0);
      no_idle = 1'b0;
      drain_results();
   endtask

   task automatic test_random_traffic();
      int stop_at;
      int frames;
      int length;
      int roll;
      logic [CODE_W-1:0] bits;
      width_style_type style;
      stop_at = items_sent + RANDOM_ITEMS;
      frames = 0;
      while (items_sent < stop_at) begin
         if (frames % 8 == 0) write_tolerance(random_tolerance());
         if (frames % 6 == 0) no_idle = ($urandom_range(0, 3) == 0);
         bits = CODE_W'($urandom);
         style = ($urandom_range(0, 4) == 0) ? WIDTH_INNER_EDGE : WIDTH_RANDOM;
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            send_frame(sync_for_unit(random_unit()), FRAME_LEN, bits, style, 0);
         end else if (roll < 80) begin
            send_frame(sync_for_unit(random_unit()), FRAME_LEN, bits, style, 8);
         end else if (roll < 90) begin
            length = $urandom_range(1, FRAME_LEN + 21);
            if (length == FRAME_LEN) length--;
            send_frame(sync_for_unit(random_unit()), length, bits, style, 0);
         end else begin
            send_noise_frame($urandom_range(1, FRAME_LEN + 11));
         end
         frames++;
      end
      no_idle = 1'b0;
   endtask

   // Duration and register transactions feed the expected decoder state.
   always @(posedge clock) begin : watch_inputs
      rpcd_result_type res;
      if (!reset && req_valid && req_ready) begin
         durations_taken++;
         if (decode_duration(req_duration, req_last, res)) begin
            pending_results.push_back(res);
            frames_closed++;
         end
      end
      if (!reset && csr_valid && csr_ready) dec_tolerance = csr_tolerance_percent;
   end

   always @(posedge clock) begin : check_results
      rpcd_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_taken++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with none expected: ok %0b code %06h base %0d",
                                      rsp_ok, rsp_code, rsp_base_unit));
         end else begin
            want = pending_results.pop_front();
            if (rsp_ok !== want.ok)
               report_mismatch($sformatf("ok %0b, expected %0b", rsp_ok, want.ok));
            if (rsp_code !== want.code)
               report_mismatch($sformatf("code %06h, expected %06h", rsp_code, want.code));
            if (rsp_base_unit !== want.base_unit)
               report_mismatch($sformatf("base unit %0d, expected %0d",
                                         rsp_base_unit, want.base_unit));
            if (want.ok) ok_frames++;
         end
      end
   end

   always @(posedge clock) begin : drive_rsp_ready
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         stall_left = random_gap();
      end
   end

   // Ends the run when no transaction of any kind has happened for too long.
   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_clean_frames();
      test_frame_length();
      test_bad_pairs();
      test_tolerance_extremes();
      test_result_backpressure();
      test_random_traffic();
      drain_results();
      $display("Run covered %0d durations in %0d frames, %0d results of which %0d decoded,",
               durations_taken, frames_closed, results_taken, ok_frames);
      $display("with %0d tolerance writes and %0d mismatches.", csr_writes, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
